>>> rtl/atg_pkg.sv
// Shared types, constants and the arctangent table of the attractor trace generator.
// Used by atg_sincos and attractor_trace_generator; it depends on nothing else.
`timescale 1ns / 1ps
package atg_pkg;

  localparam int unsigned CORDIC_STEPS = 28;
  localparam int unsigned RED_TOP      = 5;   // highest multiple 2pi << RED_TOP in the reduction

  localparam logic signed [31:0] Q_PI        = 32'sd843314857;
  localparam logic signed [31:0] Q_TWO_PI    = 32'sd1686629713;
  localparam logic signed [31:0] Q_HALF_PI   = 32'sd421657428;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd163008219;

  typedef enum logic [2:0] {
    SC_IDLE, SC_WRAP, SC_RED, SC_FOLD, SC_ROT, SC_DONE
  } sc_state_t;

  typedef enum logic [3:0] {
    T_IDLE, T_ANG_MUL, T_ANG_WAIT, T_SC, T_WX, T_WY, T_MX, T_MY, T_CHK, T_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    REG_COEFF_A, REG_COEFF_B, REG_COEFF_C, REG_COEFF_D,
    REG_ORIGIN_X, REG_ORIGIN_Y, REG_PIXELS_PER_UNIT
  } cfg_reg_t;

  // atan(2^-i) in Q.28, rounded.
  function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:  v = 32'sd210828714;
      5'd1:  v = 32'sd124459457;
      5'd2:  v = 32'sd65760959;
      5'd3:  v = 32'sd33381290;
      5'd4:  v = 32'sd16755422;
      5'd5:  v = 32'sd8385879;
      5'd6:  v = 32'sd4193963;
      5'd7:  v = 32'sd2097109;
      5'd8:  v = 32'sd1048571;
      5'd9:  v = 32'sd524287;
      5'd10: v = 32'sd262144;
      5'd11: v = 32'sd131072;
      5'd12: v = 32'sd65536;
      5'd13: v = 32'sd32768;
      5'd14: v = 32'sd16384;
      5'd15: v = 32'sd8192;
      5'd16: v = 32'sd4096;
      5'd17: v = 32'sd2048;
      5'd18: v = 32'sd1024;
      5'd19: v = 32'sd512;
      5'd20: v = 32'sd256;
      5'd21: v = 32'sd128;
      5'd22: v = 32'sd64;
      5'd23: v = 32'sd32;
      5'd24: v = 32'sd16;
      5'd25: v = 32'sd8;
      5'd26: v = 32'sd4;
      5'd27: v = 32'sd2;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/atg_sincos.sv
// Iterative sine and cosine of a Q.28 angle: modulo-2pi reduction, quadrant fold, CORDIC.
// Depends on atg_pkg.
`timescale 1ns / 1ps
module atg_sincos import atg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [35:0] angle,
  output logic               done,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  sc_state_t state_r, state_nxt;
  logic signed [37:0] r_r, r_nxt;
  logic [2:0] k_r, k_nxt;
  logic [4:0] i_r, i_nxt;
  logic signed [31:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic flip_r, flip_nxt;
  logic [37:0] mod_step;
  logic signed [37:0] t;
  logic signed [31:0] dx, dy, at;

  assign mod_step = 38'(Q_TWO_PI) << k_r;
  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;
  assign at = atan_q28(i_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SC_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    r_r    <= r_nxt;
    k_r    <= k_nxt;
    i_r    <= i_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    flip_r <= flip_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    r_nxt = r_r;
    k_nxt = k_r;
    i_nxt = i_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    flip_nxt = flip_r;
    t = (r_r > 38'(Q_PI)) ? r_r - 38'(Q_TWO_PI) : r_r;
    case (state_r)
      SC_IDLE: begin
        if (start) begin
          r_nxt = 38'(angle);
          state_nxt = SC_WRAP;
        end
      end
      SC_WRAP: begin
        // Lift a negative angle by a whole multiple of 2pi so the reduction only subtracts.
        if (r_r < 0) r_nxt = r_r + $signed(38'(Q_TWO_PI) << RED_TOP);
        k_nxt = 3'(RED_TOP);
        state_nxt = SC_RED;
      end
      SC_RED: begin
        if ($unsigned(r_r) >= mod_step) r_nxt = r_r - $signed(mod_step);
        if (k_r == 3'd0) state_nxt = SC_FOLD;
        else k_nxt = k_r - 3'd1;
      end
      SC_FOLD: begin
        flip_nxt = 1'b0;
        z_nxt = 32'(t);
        if (t > 38'(Q_HALF_PI)) begin
          z_nxt = 32'(t - 38'(Q_PI));
          flip_nxt = 1'b1;
        end else if (t < -38'(Q_HALF_PI)) begin
          z_nxt = 32'(t + 38'(Q_PI));
          flip_nxt = 1'b1;
        end
        x_nxt = CORDIC_GAIN;
        y_nxt = '0;
        i_nxt = '0;
        state_nxt = SC_ROT;
      end
      SC_ROT: begin
        if (!z_r[31]) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - at;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + at;
        end
        i_nxt = i_r + 5'd1;
        if (i_r == 5'(CORDIC_STEPS - 1)) state_nxt = SC_DONE;
      end
      SC_DONE: state_nxt = SC_IDLE;
      default: state_nxt = SC_IDLE;
    endcase
  end

  assign done  = (state_r == SC_DONE);
  assign sin_o = flip_r ? -y_r : y_r;
  assign cos_o = flip_r ? -x_r : x_r;

endmodule

>>> rtl/attractor_trace_generator.sv
// Top level of the attractor trace generator: configuration, sequencer, shared multiplier.
// Depends on atg_pkg and atg_sincos.
// A load request leaves in_tready high. A step request holds in_tready low until the
// sequencer is idle again: four sine and cosine evaluations on the one CORDIC unit, then
// weighting, mapping, range check and output, the last held while an earlier pixel waits.
// rst_n (synchronous, active low) zeroes the point, resets control and configuration registers.
`timescale 1ns / 1ps
module attractor_trace_generator import atg_pkg::*; #(
  parameter int unsigned IMAGE_WIDTH  = 1024,
  parameter int unsigned IMAGE_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // start_x [31:0], start_y [63:32]
  input  logic [0:0]  in_tuser,   // action [0]: 0 load seed, 1 step
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // pixel_x [9:0], pixel_y [19:10], zero [23:20]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Mapped values are Q.40; the image limits are scaled to match.
  localparam logic [65:0] LIM_X = 66'(IMAGE_WIDTH) << 40;
  localparam logic [65:0] LIM_Y = 66'(IMAGE_HEIGHT) << 40;

  // Configuration registers.
  logic signed [31:0] coeff_a_r, coeff_b_r, coeff_c_r, coeff_d_r, origin_x_r, origin_y_r;
  logic [23:0] ppu_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_a_r  <= 32'sd456340275;
      coeff_b_r  <= 32'sd456340275;
      coeff_c_r  <= 32'sd161061274;
      coeff_d_r  <= 32'sd322122547;
      origin_x_r <= -32'sd1073741824;
      origin_y_r <= -32'sd1073741824;
      ppu_r      <= 24'd524288;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COEFF_A:         coeff_a_r  <= cfg_data;
        REG_COEFF_B:         coeff_b_r  <= cfg_data;
        REG_COEFF_C:         coeff_c_r  <= cfg_data;
        REG_COEFF_D:         coeff_d_r  <= cfg_data;
        REG_ORIGIN_X:        origin_x_r <= cfg_data;
        REG_ORIGIN_Y:        origin_y_r <= cfg_data;
        REG_PIXELS_PER_UNIT: ppu_r      <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and datapath registers.
  top_state_t state_r, state_nxt;
  logic [1:0] eval_r;
  logic signed [31:0] point_x_r, point_y_r;
  logic signed [31:0] s_ay_r, c_ax_r, s_bx_r, c_by_r, nx_r, ny_r;
  logic signed [65:0] prod_r;
  logic signed [32:0] mul_a, mul_b;
  logic okx_r, hit_r;
  logic [9:0] px_r, py_r;
  logic out_valid_r;
  logic [19:0] out_data_r;
  logic in_fire, out_load;

  logic sc_done;
  logic signed [31:0] sc_sin, sc_cos;
  logic signed [38:0] wsum;
  logic signed [31:0] wsat;
  logic m_ok_x, m_ok_y;

  assign in_tready = (state_r == T_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  atg_sincos u_sincos (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == T_ANG_WAIT),
    .angle (prod_r[63:28]),
    .done  (sc_done),
    .sin_o (sc_sin),
    .cos_o (sc_cos)
  );

  // The one multiplier: angle products, cosine weights and the pixel mapping in turn.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      T_ANG_MUL: begin
        mul_a = 33'(eval_r[1] ? coeff_b_r : coeff_a_r);
        mul_b = 33'((eval_r == 2'd0 || eval_r == 2'd3) ? point_y_r : point_x_r);
      end
      T_WX: begin
        mul_a = 33'(coeff_c_r);
        mul_b = 33'(c_ax_r);
      end
      T_WY: begin
        mul_a = 33'(coeff_d_r);
        mul_b = 33'(c_by_r);
      end
      T_MX: begin
        mul_a = 33'(nx_r) - 33'(origin_x_r);
        mul_b = $signed({9'd0, ppu_r});
      end
      T_MY: begin
        mul_a = 33'(ny_r) - 33'(origin_y_r);
        mul_b = $signed({9'd0, ppu_r});
      end
      default: ;
    endcase
  end

  // New coordinate: sine term plus weighted cosine, saturated to 32 bits.
  always_comb begin
    wsum = 39'($signed(prod_r[65:28])) + 39'(state_r == T_WY ? s_ay_r : s_bx_r);
    if (wsum > 39'sd2147483647) wsat = 32'sh7fffffff;
    else if (wsum < -39'sd2147483648) wsat = 32'sh80000000;
    else wsat = 32'(wsum);
  end

  // A mapped value counts only strictly inside the image.
  assign m_ok_x = !prod_r[65] && (prod_r != '0) && ($unsigned(prod_r) < LIM_X);
  assign m_ok_y = !prod_r[65] && (prod_r != '0) && ($unsigned(prod_r) < LIM_Y);

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    case (state_r)
      T_IDLE:     if (in_fire && in_tuser[0]) state_nxt = T_ANG_MUL;
      T_ANG_MUL:  state_nxt = T_ANG_WAIT;
      T_ANG_WAIT: state_nxt = T_SC;
      T_SC: begin
        if (sc_done) state_nxt = (eval_r == 2'd3) ? T_WX : T_ANG_MUL;
      end
      T_WX:  state_nxt = T_WY;
      T_WY:  state_nxt = T_MX;
      T_MX:  state_nxt = T_MY;
      T_MY:  state_nxt = T_CHK;
      T_CHK: state_nxt = T_OUT;
      T_OUT: begin
        if (!hit_r) begin
          state_nxt = T_IDLE;
        end else if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      eval_r      <= '0;
      point_x_r   <= '0;
      point_y_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire && !in_tuser[0]) begin
        point_x_r <= in_tdata[31:0];
        point_y_r <= in_tdata[63:32];
      end
      if (in_fire) eval_r <= '0;
      else if (state_r == T_SC && sc_done) eval_r <= eval_r + 2'd1;
      if (state_r == T_CHK) begin
        point_x_r <= nx_r;
        point_y_r <= ny_r;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (state_r == T_SC && sc_done) begin
      case (eval_r)
        2'd0: s_ay_r <= sc_sin;
        2'd1: c_ax_r <= sc_cos;
        2'd2: s_bx_r <= sc_sin;
        default: c_by_r <= sc_cos;
      endcase
    end
    if (state_r == T_WY) nx_r <= wsat;
    if (state_r == T_MX) ny_r <= wsat;
    if (state_r == T_MY) begin
      okx_r <= m_ok_x;
      px_r  <= prod_r[49:40];
    end
    if (state_r == T_CHK) begin
      hit_r <= okx_r && m_ok_y;
      py_r  <= prod_r[49:40];
    end
    if (out_load) out_data_r <= {py_r, px_r};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_data_r};

  // The CORDIC unit only finishes while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sc_done |-> state_r == T_SC) else $error("sincos finished outside its wait state");

  // A step request makes the block busy on the next cycle.
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0]) |=> !in_tready)
    else $error("step request did not start the sequencer");

  // A load request places the seed in the point registers.
  a_load_seed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tuser[0]) |=> point_x_r == $past(in_tdata[31:0]))
    else $error("seed not loaded");

endmodule
